>>> rtl/iso_timestamp_to_epoch_top_assert.svh
// Assertion macros used by the checker file of the timestamp converter.
`ifndef ISO_TIMESTAMP_TO_EPOCH_TOP_ASSERT_SVH
`define ISO_TIMESTAMP_TO_EPOCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITSE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITSE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/itse_pkg.sv
// Shared types, constants and tables for the timestamp to epoch converter.
package itse_pkg;

    localparam int YEAR_W   = 14;
    localparam int EPOCH_W  = 38;
    localparam int POS_W    = 5;
    localparam int ACC_W    = 7;

    localparam logic [POS_W-1:0]  FIELD_LEN     = POS_W'(19);
    localparam logic [YEAR_W-1:0] MIN_YEAR_RST  = YEAR_W'(2024);
    localparam int                QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Parsed fields of one string, handed from the parser to the converter
    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } itse_rec_t;

    // Days from the first of March to the first of the given month
    function automatic logic [8:0] itse_month_offset(input logic [3:0] month);
        logic [8:0] off;
        case (month)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/iso_timestamp_to_epoch_top.sv
// ISO timestamp string to Unix epoch seconds: parser, request queue, converter.
// Throughput: one character per cycle unless full; one result per cycle for short strings.
// A parsed request reaches the output through the queue and the converter stage registers.
// The parser stalls only when the request queue is full; the converter stalls without pop.
// Reset clears parse state, the queue and all stage valid bits; min_year returns to 2024.
// No clearing pass: the block accepts input from the first cycle after reset.
module iso_timestamp_to_epoch_top #(
    parameter int QUEUE_DEPTH = itse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   char_code,
    input  logic                         last_char,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [itse_pkg::YEAR_W-1:0]  cfg_data,
    output logic                         empty,
    input  logic                         pop,
    output logic                         valid_res,
    output logic [itse_pkg::EPOCH_W-1:0] epoch_seconds
);
    import itse_pkg::*;

    itse_rec_t front_rec, queue_rec;
    logic      accept, rec_push, q_full, q_empty, rec_take;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    itse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .char_code (char_code),
        .last_char (last_char),
        .rec_push  (rec_push),
        .rec       (front_rec)
    );

    itse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (front_rec),
        .full    (q_full),
        .rd_en   (rec_take),
        .rd_data (queue_rec),
        .empty   (q_empty)
    );

    itse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (!q_empty),
        .rec           (queue_rec),
        .rec_take      (rec_take),
        .empty         (empty),
        .pop           (pop),
        .valid_res     (valid_res),
        .epoch_seconds (epoch_seconds)
    );

endmodule

>>> rtl/itse_front.sv
// Character parser: layout check, field accumulation and range checks.
module itse_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [itse_pkg::YEAR_W-1:0] cfg_data,
    input  logic                       accept,
    input  logic [7:0]                 char_code,
    input  logic                       last_char,
    output logic                       rec_push,
    output itse_pkg::itse_rec_t        rec
);
    import itse_pkg::*;

    logic [YEAR_W-1:0] min_year_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              err_reg, err_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [ACC_W-1:0]  mon_reg, mon_next;
    logic [ACC_W-1:0]  day_reg, day_next;
    logic [ACC_W-1:0]  hour_reg, hour_next;
    logic [ACC_W-1:0]  min_reg, min_next;
    logic [ACC_W-1:0]  sec_reg, sec_next;

    logic       is_digit;
    logic [3:0] digit;
    logic       ok;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit    = is_digit ? 4'(char_code - CH_ZERO) : 4'd0;

    // Classify the character by its position and fold digits in
    always_comb
    begin
        pos_next  = pos_reg;
        err_next  = err_reg;
        year_next = year_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        if (pos_reg < FIELD_LEN)
        begin
            pos_next = pos_reg + POS_W'(1);
            case (pos_reg) inside
                5'd4, 5'd7:
                    if (char_code != CH_DASH) err_next = 1'b1;
                5'd13, 5'd16:
                    if (char_code != CH_COLON) err_next = 1'b1;
                5'd10:
                    if (char_code != CH_T && char_code != CH_SPACE) err_next = 1'b1;
                default:
                begin
                    if (!is_digit)
                        err_next = 1'b1;
                    else if (pos_reg < 5'd4)
                        year_next = YEAR_W'(year_reg * YEAR_W'(10) + YEAR_W'(digit));
                    else if (pos_reg < 5'd7)
                        mon_next = ACC_W'(mon_reg * ACC_W'(10) + ACC_W'(digit));
                    else if (pos_reg < 5'd10)
                        day_next = ACC_W'(day_reg * ACC_W'(10) + ACC_W'(digit));
                    else if (pos_reg < 5'd13)
                        hour_next = ACC_W'(hour_reg * ACC_W'(10) + ACC_W'(digit));
                    else if (pos_reg < 5'd16)
                        min_next = ACC_W'(min_reg * ACC_W'(10) + ACC_W'(digit));
                    else
                        sec_next = ACC_W'(sec_reg * ACC_W'(10) + ACC_W'(digit));
                end
            endcase
        end
    end

    // Check length, layout and field ranges on the final character
    always_comb
    begin
        ok = (pos_next >= FIELD_LEN) && !err_next;
        ok = ok && (year_next >= min_year_reg);
        ok = ok && (mon_next >= ACC_W'(1)) && (mon_next <= ACC_W'(12));
        ok = ok && (day_next >= ACC_W'(1)) && (day_next <= ACC_W'(31));
        ok = ok && (hour_next <= ACC_W'(23)) && (min_next <= ACC_W'(59));
        ok = ok && (sec_next <= ACC_W'(60));
    end

    assign rec_push   = accept && last_char;
    assign rec.ok     = ok;
    assign rec.year   = year_next;
    assign rec.month  = mon_next[3:0];
    assign rec.day    = day_next[4:0];
    assign rec.hour   = hour_next[4:0];
    assign rec.minute = min_next[5:0];
    assign rec.second = sec_next[5:0];

    // Hold the lowest accepted year
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_year_reg <= MIN_YEAR_RST;
        else if (cfg_valid)
            min_year_reg <= cfg_data;
    end

    // Advance parse state, drop it after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            err_reg  <= 1'b0;
            year_reg <= '0;
            mon_reg  <= '0;
            day_reg  <= '0;
            hour_reg <= '0;
            min_reg  <= '0;
            sec_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                pos_reg  <= '0;
                err_reg  <= 1'b0;
                year_reg <= '0;
                mon_reg  <= '0;
                day_reg  <= '0;
                hour_reg <= '0;
                min_reg  <= '0;
                sec_reg  <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                err_reg  <= err_next;
                year_reg <= year_next;
                mon_reg  <= mon_next;
                day_reg  <= day_next;
                hour_reg <= hour_next;
                min_reg  <= min_next;
                sec_reg  <= sec_next;
            end
        end
    end

endmodule

>>> rtl/itse_queue.sv
// Short queue of parsed requests between the parser and the converter.
module itse_queue #(
    parameter int DEPTH = itse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  itse_pkg::itse_rec_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output itse_pkg::itse_rec_t rd_data,
    output logic                empty
);
    import itse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itse_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Store a request
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

>>> rtl/itse_back.sv
// Three-stage days-from-civil converter with the result register at its end.
module itse_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rec_valid,
    input  itse_pkg::itse_rec_t           rec,
    output logic                          rec_take,
    output logic                          empty,
    input  logic                          pop,
    output logic                          valid_res,
    output logic [itse_pkg::EPOCH_W-1:0]  epoch_seconds
);
    import itse_pkg::*;

    // Stage one: products and table look-up
    logic         s1_v_reg, s1_ok_reg;
    logic [11:0]  s1_z_reg;
    logic [23:0]  s1_prod_reg;
    logic [22:0]  s1_y365_reg;
    logic [8:0]   s1_doy_reg;
    logic [16:0]  s1_tod_reg;
    // Stage two: day count
    logic               s2_v_reg, s2_ok_reg;
    logic signed [23:0] s2_days_reg;
    logic [16:0]        s2_tod_reg;
    // Stage three: result register
    logic               s3_v_reg;
    logic               res_ok_reg;
    logic [EPOCH_W-1:0] res_epoch_reg;

    logic rdy1, rdy2, rdy3;

    logic              mon_le2;
    logic [YEAR_W-1:0] y_w;
    logic [11:0]       z_w;
    logic              ok1_w;
    logic [7:0]        q_w;
    logic [22:0]       sum_w;
    logic signed [23:0] days_w;
    logic signed [41:0] epoch_w;
    logic              ok3_w;

    assign rdy3     = !s3_v_reg || pop;
    assign rdy2     = !s2_v_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign rec_take = rec_valid && rdy1;

    // Shift the year to a March start; year zero before March lies before 1970
    assign mon_le2 = (rec.month <= 4'd2);
    assign y_w     = rec.year - YEAR_W'(mon_le2);
    assign z_w     = y_w[YEAR_W-1:2];
    assign ok1_w   = rec.ok && !(mon_le2 && rec.year == '0);

    // Year/100 from (year/4)/25 by reciprocal multiply
    assign q_w   = s1_prod_reg[23:16];
    assign sum_w = s1_y365_reg + 23'(s1_z_reg) + 23'(q_w[7:2]) + 23'(s1_doy_reg);
    assign days_w = $signed({1'b0, sum_w}) - $signed({16'b0, q_w}) - 24'sd719468;

    assign epoch_w = 42'(s2_days_reg) * 42'sd86400 + $signed({25'b0, s2_tod_reg});
    assign ok3_w   = s2_ok_reg && !epoch_w[41];

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_ok_reg   <= ok1_w;
            s1_z_reg    <= z_w;
            s1_prod_reg <= 24'(z_w) * 24'd2622;
            s1_y365_reg <= 23'(y_w) * 23'd365;
            s1_doy_reg  <= 9'(itse_month_offset(rec.month) + 9'(rec.day) - 9'd1);
            s1_tod_reg  <= 17'(rec.hour) * 17'd3600 + 17'(rec.minute) * 17'd60
                           + 17'(rec.second);
        end
        if (rdy2)
        begin
            s2_ok_reg   <= s1_ok_reg;
            s2_days_reg <= days_w;
            s2_tod_reg  <= s1_tod_reg;
        end
        if (rdy3)
        begin
            res_ok_reg    <= ok3_w;
            res_epoch_reg <= ok3_w ? epoch_w[EPOCH_W-1:0] : '0;
        end
    end

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_v_reg <= rec_valid;
            if (rdy2) s2_v_reg <= s1_v_reg;
            if (rdy3) s3_v_reg <= s2_v_reg;
        end
    end

    assign empty         = !s3_v_reg;
    assign valid_res     = res_ok_reg;
    assign epoch_seconds = res_epoch_reg;

endmodule

>>> rtl/itse_checker.sv
// Port-level checker for the timestamp converter and its bind.
`include "iso_timestamp_to_epoch_top_assert.svh"

module itse_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  logic                         pop,
    input  logic                         valid_res,
    input  logic [itse_pkg::EPOCH_W-1:0] epoch_seconds
);
    import itse_pkg::*;

    // A rejected string carries no seconds
    `ITSE_ASSERT_IMP(a_invalid_zero, clk, rst_n, !empty && !valid_res, epoch_seconds == '0, "invalid result with nonzero epoch")

    // Accepted times never pass the end of year 9999
    `ITSE_ASSERT_IMP(a_epoch_bound, clk, rst_n, !empty && valid_res, epoch_seconds <= 38'd253402300800, "epoch beyond year 9999")

    // A waiting result holds until it is taken
    `ITSE_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(valid_res) && $stable(epoch_seconds), "stalled result changed")

endmodule

bind iso_timestamp_to_epoch_top itse_checker u_itse_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the timestamp to epoch converter: table, random strings, predictor.
module testbench;
    import itse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam int BLOCK_CHARS = 60;
    localparam int HOLD_BLOCK_CHARS = 180;
    localparam int HOLD_CYCLES = 400;
    localparam int NO_SUB = -1;

    typedef struct packed {
        logic               ok;
        logic [EPOCH_W-1:0] secs;
    } stamp_result_t;

    typedef struct {
        int     year_floor;
        string  text;
        int     sub_pos;
        int     sub_byte;
        bit     typed;
        bit     exp_ok;
        longint exp_secs;
    } stamp_row_t;

    // Directed strings; typed rows carry the result that can be read off directly
    stamp_row_t dir_rows [0:26] = '{
        '{2024, "2024-01-01T00:00:00",        NO_SUB, 0,     1, 1, 64'd1704067200},
        '{2024, "2023-12-31T23:59:59",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-01-01T00:00",           NO_SUB, 0,     1, 0, 0},
        '{2024, "7",                          NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-03-15 12:34:56Z+01:00", NO_SUB, 0,     0, 0, 0},
        '{2024, "2024-02-31T10:00:00",        NO_SUB, 0,     0, 0, 0},
        '{2024, "2024-13-01T00:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-00-10T00:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-00T00:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-32T00:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-05T24:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-05T23:60:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-05T23:59:61",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-06-30T23:59:60",        NO_SUB, 0,     0, 0, 0},
        '{2024, "2024/05-05T00:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-05X00:00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-05T00-00:00",        NO_SUB, 0,     1, 0, 0},
        '{2024, "2024-05-05T00:00:00",        5,      8'h00, 1, 0, 0},
        '{2024, "2024-05-05T00:00:00",        18,     8'hFF, 1, 0, 0},
        '{2024, "2024-05-05T00:00:00abc",     20,     8'hFF, 0, 0, 0},
        '{0,    "1970-01-01T00:00:00",        NO_SUB, 0,     1, 1, 0},
        '{0,    "1969-12-31T23:59:59",        NO_SUB, 0,     1, 0, 0},
        '{0,    "0000-01-01T00:00:00",        NO_SUB, 0,     0, 0, 0},
        '{0,    "9999-12-31T23:59:60",        NO_SUB, 0,     1, 1, 64'd253402300800},
        '{9999, "9998-12-31T23:59:59",        NO_SUB, 0,     1, 0, 0},
        '{9999, "9999-01-01T00:00:00",        NO_SUB, 0,     0, 0, 0},
        '{2024, "2038-01-19T03:14:08",        NO_SUB, 0,     0, 0, 0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         char_code = 8'h00;
    logic               last_char = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [YEAR_W-1:0]  cfg_data = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               valid_res;
    logic [EPOCH_W-1:0] epoch_seconds;

    // Predictor copy of the parser state and the year floor
    int                 pred_pos;
    bit                 pred_fmt_err;
    int                 pred_year;
    int                 pred_month;
    int                 pred_day;
    int                 pred_hour;
    int                 pred_minute;
    int                 pred_second;
    int                 pred_min_year;

    stamp_result_t      epoch_expected_q [$];
    logic [7:0]         line_bytes [$];
    int                 err_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    bit                 hold_req = 1'b0;
    bit                 hold_taken = 1'b0;
    int                 hold_left = 0;

    iso_timestamp_to_epoch_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .last_char     (last_char),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .empty         (empty),
        .pop           (pop),
        .valid_res     (valid_res),
        .epoch_seconds (epoch_seconds)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Days-from-civil conversion to seconds, fields taken as UTC
    function automatic longint civil_to_secs(longint yr, longint mo, longint dy,
                                             longint hr, longint mi, longint se);
        longint y;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        longint days;
        y = yr - ((mo <= 2) ? 1 : 0);
        era = ((y >= 0) ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (mo + ((mo > 2) ? -3 : 9)) + 2) / 5 + dy - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        return days * 86400 + hr * 3600 + mi * 60 + se;
    endfunction

    function automatic void clear_parse_state();
        pred_pos = 0;
        pred_fmt_err = 1'b0;
        pred_year = 0;
        pred_month = 0;
        pred_day = 0;
        pred_hour = 0;
        pred_minute = 0;
        pred_second = 0;
    endfunction

    // Advance the predictor by one accepted character; report a result on the final one
    function automatic bit predict_char(logic [7:0] c, logic fin, output stamp_result_t res);
        bit     dig;
        int     d;
        bit     ok;
        longint secs;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d = dig ? int'(c - CH_ZERO) : 0;
        res = '0;
        if (pred_pos < int'(FIELD_LEN))
        begin
            if (pred_pos == 4 || pred_pos == 7)
            begin
                if (c != CH_DASH)
                    pred_fmt_err = 1'b1;
            end
            else if (pred_pos == 13 || pred_pos == 16)
            begin
                if (c != CH_COLON)
                    pred_fmt_err = 1'b1;
            end
            else if (pred_pos == 10)
            begin
                if (c != CH_T && c != CH_SPACE)
                    pred_fmt_err = 1'b1;
            end
            else if (!dig)
                pred_fmt_err = 1'b1;
            else if (pred_pos < 4)
                pred_year = (pred_year * 10 + d) & 16'h3FFF;
            else if (pred_pos < 7)
                pred_month = (pred_month * 10 + d) & 8'h7F;
            else if (pred_pos < 10)
                pred_day = (pred_day * 10 + d) & 8'h7F;
            else if (pred_pos < 13)
                pred_hour = (pred_hour * 10 + d) & 8'h7F;
            else if (pred_pos < 16)
                pred_minute = (pred_minute * 10 + d) & 8'h7F;
            else
                pred_second = (pred_second * 10 + d) & 8'h7F;
            pred_pos++;
        end
        if (!fin)
            return 1'b0;
        ok = (pred_pos >= int'(FIELD_LEN)) && !pred_fmt_err;
        ok = ok && (pred_year >= pred_min_year);
        ok = ok && (pred_month >= 1) && (pred_month <= 12);
        ok = ok && (pred_day >= 1) && (pred_day <= 31);
        ok = ok && (pred_hour <= 23) && (pred_minute <= 59) && (pred_second <= 60);
        secs = 0;
        if (ok)
        begin
            secs = civil_to_secs(pred_year, pred_month, pred_day,
                                 pred_hour, pred_minute, pred_second);
            if (secs < 0)
                ok = 1'b0;
        end
        res.ok = ok;
        res.secs = ok ? secs[EPOCH_W-1:0] : '0;
        clear_parse_state();
        return 1'b1;
    endfunction

    // Offer one character, hold it until taken, then log the expected result
    task automatic send_char(logic [7:0] c, logic fin, bit use_typed, stamp_result_t typed_res);
        stamp_result_t res;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        char_code <= c;
        last_char <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (predict_char(c, fin, res))
            epoch_expected_q.push_back(use_typed ? typed_res : res);
    endtask

    // Hold input off until every expected result has come back, then let the block settle
    task automatic wait_all_returned();
        push <= 1'b0;
        while (epoch_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_year(int value);
        wait_all_returned();
        cfg_valid <= 1'b1;
        cfg_data <= YEAR_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pred_min_year = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic void append_digits(int value, int ndig);
        int div;
        div = 1;
        for (int i = 1; i < ndig; i++)
            div = div * 10;
        for (int i = 0; i < ndig; i++)
        begin
            line_bytes.push_back(CH_ZERO + 8'((value / div) % 10));
            div = div / 10;
        end
    endfunction

    function automatic int pick_field(int hi, int pct_in_range);
        if ($urandom_range(99, 0) < pct_in_range)
            return $urandom_range(hi, 0);
        return $urandom_range(99, 0);
    endfunction

    // Build one random string: mostly well formed, some broken, some noise
    function automatic void build_random_stamp(int floor_yr);
        int kind;
        int yr;
        int r;
        int n;
        int lo;
        int hi;
        line_bytes.delete();
        kind = $urandom_range(99, 0);
        if (kind < 15)
        begin
            n = $urandom_range(30, 1);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(8'($urandom_range(255, 0)));
            return;
        end
        r = $urandom_range(9, 0);
        lo = (floor_yr > 3) ? floor_yr - 3 : 0;
        hi = (floor_yr < 9996) ? floor_yr + 3 : 9999;
        if (r < 5)
            yr = $urandom_range(9999, floor_yr);
        else if (r < 7)
            yr = $urandom_range(hi, lo);
        else if (r < 9)
            yr = $urandom_range(2100, 1960);
        else
            yr = $urandom_range(9999, 0);
        append_digits(yr, 4);
        line_bytes.push_back(CH_DASH);
        r = pick_field(11, 88);
        append_digits((r <= 11 && $urandom_range(99, 0) < 88) ? r + 1 : r, 2);
        line_bytes.push_back(CH_DASH);
        r = pick_field(30, 88);
        append_digits((r <= 30 && $urandom_range(99, 0) < 88) ? r + 1 : r, 2);
        line_bytes.push_back($urandom_range(1, 0) ? CH_T : CH_SPACE);
        append_digits(pick_field(23, 90), 2);
        line_bytes.push_back(CH_COLON);
        append_digits(pick_field(59, 90), 2);
        line_bytes.push_back(CH_COLON);
        append_digits(pick_field(60, 90), 2);
        if (kind < 30)
        begin
            if ($urandom_range(1, 0))
                line_bytes[$urandom_range(18, 0)] = 8'($urandom_range(255, 0));
            else
            begin
                n = $urandom_range(18, 1);
                line_bytes = line_bytes[0:n-1];
            end
        end
        if ($urandom_range(99, 0) < 20)
        begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
        if (err_count < 10)
            $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
        err_count++;
    endfunction

    // Receiver: pop at random, check each result against the oldest request
    initial
    begin
        stamp_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (epoch_expected_q.size() == 0)
                    note_mismatch("result with no request waiting", 0, 1);
                else
                begin
                    want = epoch_expected_q.pop_front();
                    if (valid_res !== want.ok)
                        note_mismatch("valid_res", 64'(want.ok), 64'(valid_res));
                    if (epoch_seconds !== want.secs)
                        note_mismatch("epoch_seconds", 64'(want.secs), 64'(epoch_seconds));
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Sender: reset, directed table, random blocks, drain
    initial
    begin
        stamp_result_t typed_res;
        stamp_row_t    row;
        logic [7:0]    c;
        int            len;
        int            block_chars;
        int            block_len;
        int            floor_yr;
        pred_min_year = int'(MIN_YEAR_RST);
        clear_parse_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 14;
        recv_idle_pct = 85;
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.year_floor != pred_min_year)
                write_min_year(row.year_floor);
            typed_res.ok = row.exp_ok;
            typed_res.secs = row.exp_secs[EPOCH_W-1:0];
            len = row.text.len();
            for (int i = 0; i < len; i++)
            begin
                c = (i == row.sub_pos) ? 8'(row.sub_byte) : 8'(row.text[i]);
                send_char(c, i == len - 1, row.typed, typed_res);
            end
        end

        for (int blk = 0; blk < 6; blk++)
        begin
            send_idle_pct = (blk < 2) ? 14 : (blk < 4) ? 85 : 0;
            recv_idle_pct = (blk < 2) ? 85 : (blk < 4) ? 14 : 0;
            case (blk)
                1, 4:    floor_yr = 0;
                2:       floor_yr = 9999;
                5:       floor_yr = int'(MIN_YEAR_RST);
                default: floor_yr = $urandom_range(9999, 0);
            endcase
            write_min_year(floor_yr);
            // long receiver hold-off while strings keep coming
            if (blk == 4)
                hold_req = 1'b1;
            block_len = (blk == 4) ? HOLD_BLOCK_CHARS : BLOCK_CHARS;
            block_chars = 0;
            while (block_chars < block_len)
            begin
                build_random_stamp(floor_yr);
                typed_res = '0;
                foreach (line_bytes[i])
                    send_char(line_bytes[i], i == line_bytes.size() - 1, 1'b0, typed_res);
                block_chars += line_bytes.size();
            end
        end

        wait_all_returned();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && epoch_expected_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
